[hdl/cbt_pkg.sv]
// Package for the circuit breaker table: codes, record layout, helpers.
// No dependencies.
`default_nettype none
package cbt_pkg;
    localparam logic [2:0] ACT_SUCCESS = 3'd0;
    localparam logic [2:0] ACT_FAILURE = 3'd1;
    localparam logic [2:0] ACT_REQUEST = 3'd2;
    localparam logic [2:0] ACT_QUERY   = 3'd3;
    localparam logic [2:0] ACT_RESET   = 3'd4;
    localparam logic [2:0] ACT_OBSERVE = 3'd5;
    localparam logic [2:0] ACT_READ    = 3'd6;

    localparam logic [2:0] SEL_SUCCESS = 3'd0;
    localparam logic [2:0] SEL_FAILURE = 3'd1;
    localparam logic [2:0] SEL_TRIPS   = 3'd2;
    localparam logic [2:0] SEL_ADMIT   = 3'd3;
    localparam logic [2:0] SEL_REFUSE  = 3'd4;
    localparam logic [2:0] SEL_RUN     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOENTRY = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] MODE_CLOSED = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;

    localparam logic [15:0] RESET_THRESHOLD = 16'd5;
    localparam logic [31:0] RESET_COOLDOWN  = 32'd1000;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_COOLDOWN  = 2'd1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} fsm_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] run;
        logic [47:0] opened;
        logic        trial;
        logic [31:0] succ;
        logic [31:0] fail;
        logic [31:0] trips;
        logic [31:0] admit;
        logic [31:0] refuse;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    function automatic logic [31:0] sat32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction
endpackage
`default_nettype wire

[hdl/cbt_ram.sv]
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module cbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hdl/circuit_breaker_table.sv]
// Circuit breaker table: item in, one result beat out per item.
// The result is registered in S_READ and valid in S_OUT; one item at a time, so a new
// item is accepted only after the result is taken, set by the record read-modify-write in RAM.
// Synchronous active-low reset clears the valid bits and the FSM state and loads the config defaults.
// Depends on cbt_pkg and cbt_ram.
`default_nettype none
module circuit_breaker_table #(
    parameter int ENTRIES = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    // action[2:0], service_key[18:3], now_tick[66:19], observed_failing[67],
    // counter_select[70:68], zero pad
    input  wire  [71:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // status[1:0], permitted[2], breaker_state[4:3], tripped[5],
    // counter_value[37:6], zero pad
    output logic [39:0] m_tdata
);
    import cbt_pkg::*;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [15:0] thr_reg;
    logic [31:0] cool_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [15:0] key_reg [ENTRIES];
    fsm_t state_reg, state_next;

    logic [2:0]  act_reg;
    logic [47:0] now_reg;
    logic        obs_reg;
    logic [2:0]  sel_reg;
    logic        hit_reg, full_reg;
    logic [AW-1:0] slot_reg;
    logic        fresh_reg;
    logic [39:0] out_reg;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {16'd0, thr_reg};
            default: prdata = cool_reg;
        endcase
    end

    wire [2:0]  in_act = s_tdata[2:0];
    wire [15:0] in_key = s_tdata[18:3];
    wire creates = (in_act == ACT_SUCCESS) || (in_act == ACT_FAILURE) ||
                   (in_act == ACT_OBSERVE);

    logic          m_hit, f_any;
    logic [AW-1:0] m_idx, f_idx;
    always_comb begin
        m_hit = 1'b0; m_idx = '0; f_any = 1'b0; f_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && key_reg[i] == in_key) begin
                m_hit = 1'b1; m_idx = AW'(i);
            end
            if (!valid_reg[i]) begin
                f_any = 1'b1; f_idx = AW'(i);
            end
        end
    end

    wire acc = s_tvalid && s_tready;
    rec_t rd, wr;
    logic we;
    logic [1:0] st;
    logic perm, trp;
    logic [31:0] val;

    cbt_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
        .aclk(aclk), .we(we), .waddr(slot_reg), .wdata(wr),
        .raddr(acc ? (m_hit ? m_idx : f_idx) : slot_reg), .rdata(rd)
    );

    always_comb begin
        rec_t r;
        logic [47:0] el;
        r = fresh_reg ? rec_t'('0) : rd;
        st = ST_OK; perm = 1'b0; trp = 1'b0; val = '0;
        el = (now_reg > r.opened) ? now_reg - r.opened : 48'd0;
        if (!hit_reg) begin
            if (full_reg) st = ST_FULL;
            else begin
                st = ST_NOENTRY;
                perm = (act_reg == ACT_REQUEST);
            end
        end else begin
            case (act_reg)
                ACT_SUCCESS: begin
                    r.succ = sat32(r.succ); r.run = '0; r.trial = 1'b0;
                    if (r.mode == MODE_HALF) r.mode = MODE_CLOSED;
                end
                ACT_FAILURE, ACT_OBSERVE: begin
                    if (act_reg == ACT_OBSERVE && !obs_reg) begin
                        if (r.mode == MODE_CLOSED) r.run = '0;
                    end else begin
                        r.fail = sat32(r.fail); r.run = sat16(r.run);
                        if (act_reg == ACT_FAILURE) begin
                            r.trial = 1'b0;
                            if (r.mode == MODE_HALF) begin
                                r.mode = MODE_CLOSED; trp = 1'b1;
                            end else if (r.mode == MODE_CLOSED && r.run >= thr_reg)
                                trp = 1'b1;
                        end else if (r.mode == MODE_CLOSED && r.run >= thr_reg)
                            trp = 1'b1;
                        if (trp) begin
                            r.mode = MODE_OPEN; r.opened = now_reg;
                            r.trial = 1'b0; r.trips = sat32(r.trips);
                        end
                    end
                end
                ACT_REQUEST: begin
                    if (r.mode == MODE_CLOSED) begin
                        r.admit = sat32(r.admit); perm = 1'b1;
                    end else if (r.mode == MODE_OPEN) begin
                        if (el < {16'd0, cool_reg}) r.refuse = sat32(r.refuse);
                        else begin
                            r.mode = MODE_HALF; r.trial = 1'b1;
                            r.admit = sat32(r.admit); perm = 1'b1;
                        end
                    end else if (r.trial) r.refuse = sat32(r.refuse);
                    else begin
                        r.trial = 1'b1; r.admit = sat32(r.admit); perm = 1'b1;
                    end
                end
                ACT_RESET: begin
                    r.mode = MODE_CLOSED; r.run = '0; r.trial = 1'b0;
                end
                ACT_READ: begin
                    case (sel_reg)
                        SEL_SUCCESS: val = r.succ;
                        SEL_FAILURE: val = r.fail;
                        SEL_TRIPS:   val = r.trips;
                        SEL_ADMIT:   val = r.admit;
                        SEL_REFUSE:  val = r.refuse;
                        SEL_RUN:     val = {16'd0, r.run};
                        default:     val = '0;
                    endcase
                end
                default: ;
            endcase
        end
        wr = r;
    end

    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        we = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = S_READ;
            end
            S_READ: begin
                we = hit_reg;
                state_next = S_OUT;
            end
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            thr_reg <= RESET_THRESHOLD;
            cool_reg <= RESET_COOLDOWN;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite) begin
                if ({1'b0, paddr[2]} == REG_THRESHOLD) thr_reg <= pwdata[15:0];
                else if ({1'b0, paddr[2]} == REG_COOLDOWN) cool_reg <= pwdata;
            end
            if (acc && !m_hit && creates && f_any) valid_reg[f_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            act_reg <= in_act;
            now_reg <= s_tdata[66:19];
            obs_reg <= s_tdata[67];
            sel_reg <= s_tdata[70:68];
            hit_reg <= m_hit || (creates && f_any);
            full_reg <= creates && !f_any;
            fresh_reg <= !m_hit;
            slot_reg <= m_hit ? m_idx : f_idx;
            if (!m_hit && creates && f_any) key_reg[f_idx] <= in_key;
        end
        if (state_reg == S_READ)
            out_reg <= {2'b00, val, trp, hit_reg ? wr.mode : MODE_CLOSED, perm, st};
    end
endmodule
`default_nettype wire

[hdl/cbt_checker.sv]
// Port-level checks for circuit_breaker_table, bound to the top level.
// Depends on cbt_pkg.
`default_nettype none
module cbt_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);
    import cbt_pkg::*;
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid) else $error("no result");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[37:2] == '0)
        else $error("full result not clean");
endmodule
bind circuit_breaker_table cbt_checker u_chk (.*);
`default_nettype wire

[verif/circuit_breaker_table_checker.sv]
// Checker for the circuit breaker table: watches both streams, predicts each
// result beat from its own copy of the table and counts mismatches. Uses cbt_pkg.
module circuit_breaker_table_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [71:0] s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [39:0] m_tdata,
    output int          errors,
    output int          pending
);
    import cbt_pkg::*;

    localparam int N = 16;

    typedef struct packed {
        logic [31:0] value;
        logic        tripped;
        logic [1:0]  mode;
        logic        perm;
        logic [1:0]  status;
    } verdict_t;

    logic [15:0] threshold;
    logic [31:0] cooldown;
    logic        used [N];
    logic [15:0] keys [N];
    rec_t        tbl [N];
    verdict_t    expected_q [$];

    assign pending = expected_q.size();

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic int lookup(input logic [15:0] key);
        for (int i = 0; i < N; i++)
            if (used[i] && keys[i] == key) return i;
        return -1;
    endfunction

    function automatic logic trip_entry(input int i, input logic [47:0] now);
        if (tbl[i].mode == MODE_OPEN) return 1'b0;
        tbl[i].mode = MODE_OPEN;
        tbl[i].opened = now;
        tbl[i].trial = 1'b0;
        tbl[i].trips = sat32(tbl[i].trips);
        return 1'b1;
    endfunction

    function automatic verdict_t breaker_step(input logic [71:0] d);
        logic [2:0]  act;
        logic [15:0] key;
        logic [47:0] now;
        logic        failing;
        logic [2:0]  sel;
        logic        creates;
        logic [47:0] elapsed;
        int          i;
        verdict_t    r;
        act = d[2:0];
        key = d[18:3];
        now = d[66:19];
        failing = d[67];
        sel = d[70:68];
        r = '0;
        creates = act == ACT_SUCCESS || act == ACT_FAILURE || act == ACT_OBSERVE;
        i = lookup(key);
        if (i < 0 && creates) begin
            for (int j = 0; j < N; j++) begin
                if (!used[j]) begin
                    used[j] = 1'b1;
                    keys[j] = key;
                    tbl[j] = '0;
                    i = j;
                    break;
                end
            end
        end
        if (i < 0) begin
            if (creates) begin
                r.status = ST_FULL;
            end else begin
                r.status = ST_NOENTRY;
                r.perm = act == ACT_REQUEST;
            end
            return r;
        end
        case (act)
            ACT_SUCCESS: begin
                tbl[i].succ = sat32(tbl[i].succ);
                tbl[i].run = '0;
                tbl[i].trial = 1'b0;
                if (tbl[i].mode == MODE_HALF) tbl[i].mode = MODE_CLOSED;
            end
            ACT_FAILURE: begin
                tbl[i].fail = sat32(tbl[i].fail);
                tbl[i].run = sat16(tbl[i].run);
                tbl[i].trial = 1'b0;
                if (tbl[i].mode == MODE_HALF) begin
                    tbl[i].mode = MODE_CLOSED;
                    r.tripped = trip_entry(i, now);
                end else if (tbl[i].mode == MODE_CLOSED && tbl[i].run >= threshold) begin
                    r.tripped = trip_entry(i, now);
                end
            end
            ACT_REQUEST: begin
                if (tbl[i].mode == MODE_CLOSED) begin
                    tbl[i].admit = sat32(tbl[i].admit);
                    r.perm = 1'b1;
                end else if (tbl[i].mode == MODE_OPEN) begin
                    elapsed = now > tbl[i].opened ? now - tbl[i].opened : '0;
                    if (elapsed < {16'd0, cooldown}) begin
                        tbl[i].refuse = sat32(tbl[i].refuse);
                    end else begin
                        tbl[i].mode = MODE_HALF;
                        tbl[i].trial = 1'b1;
                        tbl[i].admit = sat32(tbl[i].admit);
                        r.perm = 1'b1;
                    end
                end else if (tbl[i].trial) begin
                    tbl[i].refuse = sat32(tbl[i].refuse);
                end else begin
                    tbl[i].trial = 1'b1;
                    tbl[i].admit = sat32(tbl[i].admit);
                    r.perm = 1'b1;
                end
            end
            ACT_RESET: begin
                tbl[i].mode = MODE_CLOSED;
                tbl[i].run = '0;
                tbl[i].trial = 1'b0;
            end
            ACT_OBSERVE: begin
                if (!failing) begin
                    if (tbl[i].mode == MODE_CLOSED) tbl[i].run = '0;
                end else begin
                    tbl[i].fail = sat32(tbl[i].fail);
                    tbl[i].run = sat16(tbl[i].run);
                    if (tbl[i].mode == MODE_CLOSED && tbl[i].run >= threshold)
                        r.tripped = trip_entry(i, now);
                end
            end
            ACT_READ: begin
                case (sel)
                    SEL_SUCCESS: r.value = tbl[i].succ;
                    SEL_FAILURE: r.value = tbl[i].fail;
                    SEL_TRIPS:   r.value = tbl[i].trips;
                    SEL_ADMIT:   r.value = tbl[i].admit;
                    SEL_REFUSE:  r.value = tbl[i].refuse;
                    SEL_RUN:     r.value = {16'd0, tbl[i].run};
                    default:     r.value = '0;
                endcase
            end
            default: ;
        endcase
        r.mode = tbl[i].mode;
        return r;
    endfunction

    always @(posedge aclk) begin
        verdict_t want, got;
        if (!aresetn) begin
            threshold <= RESET_THRESHOLD;
            cooldown <= RESET_COOLDOWN;
            for (int i = 0; i < N; i++) used[i] = 1'b0;
            expected_q.delete();
            errors <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_COOLDOWN[0]) cooldown <= pwdata;
                else threshold <= pwdata[15:0];
            end
            if (s_tvalid && s_tready) expected_q.push_back(breaker_step(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[37:0];
                if (expected_q.size() == 0) begin
                    report("unexpected beat", m_tdata, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status != want.status)
                        report("status", 40'(got.status), 40'(want.status));
                    if (got.perm != want.perm)
                        report("permitted", 40'(got.perm), 40'(want.perm));
                    if (got.mode != want.mode)
                        report("state", 40'(got.mode), 40'(want.mode));
                    if (got.tripped != want.tripped)
                        report("tripped", 40'(got.tripped), 40'(want.tripped));
                    if (got.value != want.value)
                        report("counter", 40'(got.value), 40'(want.value));
                end
            end
        end
    end
endmodule

[verif/circuit_breaker_table_test.sv]
// Testbench top for the circuit breaker table: APB setup, directed and random
// beats with idle phases and a long output stall. Needs the checker and cbt_pkg.
module circuit_breaker_table_test;
    import cbt_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          errors, pending;
    int          cycles = 0;
    int          send_idle = 0, recv_stall = 0;
    logic        hold_off = 1'b0;
    logic [47:0] clock_now = 48'd5000;

    always #2 aclk = ~aclk;

    circuit_breaker_table i_dut (.*);

    circuit_breaker_table_checker i_check (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx[0], 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // tvalid stays up after the accepting edge until the next beat, an idle
    // gap or a drain replaces it, so it is assigned once per time step
    task automatic send(input logic [2:0] act, input logic [15:0] key, input logic [47:0] now,
                        input logic flag, input logic [2:0] sel);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, sel, flag, now, key, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic random_items(input int n, input int keyspan);
        logic [47:0] now;
        for (int k = 0; k < n; k++) begin
            clock_now = clock_now + 48'($urandom_range(300));
            now = clock_now;
            if ($urandom_range(19) == 0) now = 48'({$urandom, $urandom});
            send($urandom_range(9) < 9 ? 3'($urandom_range(6)) : 3'($urandom_range(7)),
                 $urandom_range(19) == 0 ? 16'($urandom) : 16'($urandom_range(keyspan)),
                 now, 1'($urandom), 3'($urandom_range(7)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: defaults, absent keys, trip, cooldown, half-open paths
        send(ACT_QUERY, 16'hFFFF, 48'd0, 1'b0, SEL_SUCCESS);
        send(ACT_REQUEST, 16'h0, 48'd0, 1'b0, SEL_SUCCESS);
        send(ACT_READ, 16'h0, 48'd0, 1'b0, SEL_RUN);
        send(3'd7, 16'h0, 48'd0, 1'b0, SEL_SUCCESS);
        for (int k = 0; k < 5; k++) send(ACT_FAILURE, 16'h1, 48'd100, 1'b0, SEL_SUCCESS);
        send(ACT_FAILURE, 16'h1, 48'd200, 1'b0, SEL_SUCCESS);
        send(ACT_REQUEST, 16'h1, 48'd50, 1'b0, SEL_SUCCESS);
        send(ACT_REQUEST, 16'h1, 48'd1100, 1'b0, SEL_SUCCESS);
        send(ACT_REQUEST, 16'h1, 48'd1100, 1'b0, SEL_SUCCESS);
        send(ACT_FAILURE, 16'h1, 48'hFFFF_FFFF_FFFF, 1'b0, SEL_SUCCESS);
        send(ACT_OBSERVE, 16'h1, 48'd0, 1'b1, SEL_SUCCESS);
        send(ACT_RESET, 16'h1, 48'd0, 1'b0, SEL_SUCCESS);
        send(ACT_OBSERVE, 16'hFFFF, 48'd0, 1'b0, SEL_SUCCESS);
        for (int s = 0; s < 8; s++) send(ACT_READ, 16'h1, 48'd0, 1'b0, 3'(s));
        drain();
        write_reg(REG_THRESHOLD, 32'd0);
        write_reg(REG_COOLDOWN, 32'd0);
        random_items(120, 20);
        drain();
        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_COOLDOWN, 32'hFFFF_FFFF);
        send_idle = 53;
        random_items(120, 20);
        drain();
        write_reg(REG_THRESHOLD, 32'd2);
        write_reg(REG_COOLDOWN, 32'd150);
        send_idle = 0; recv_stall = 53;
        random_items(300, 24);
        // long hold-off so the block backs up
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_items(30, 24);
        join
        drain();
        write_reg(REG_THRESHOLD, 32'd3);
        write_reg(REG_COOLDOWN, 32'd400);
        send_idle = 35; recv_stall = 35;
        random_items(300, 24);
        send_idle = 0; recv_stall = 0;
        random_items(350, 24);
        drain();
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
